/* rtl/telnet_command_strip_keyword_detect_macros.svh */
// Assertion macros shared by the telnet command strip and keyword detect RTL.
`ifndef TELNET_COMMAND_STRIP_KEYWORD_DETECT_MACROS_SVH
`define TELNET_COMMAND_STRIP_KEYWORD_DETECT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define TCSK_ASSERT_IMPLIES(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define TCSK_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* rtl/telcsk_pkg.sv */
// Shared types, constants and helpers for the telnet command strip and keyword detect block.
package telcsk_pkg;

    localparam int DATA_W       = 8;
    localparam int WINDOW_BYTES = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_COUNT   = 6;
    localparam int MAX_WORD_LEN = 9;

    localparam logic [DATA_W-1:0] IAC_CODE    = 8'hff;
    localparam logic [DATA_W-1:0] SB_CODE     = 8'hfa;
    localparam logic [DATA_W-1:0] NUL_CODE    = 8'h00;
    localparam logic [DATA_W-1:0] UPPER_A     = 8'h41;
    localparam logic [DATA_W-1:0] UPPER_Z     = 8'h5a;
    localparam logic [DATA_W-1:0] CASE_OFFSET = 8'h20;

    // Flag positions, one per keyword
    localparam int FLAG_LOGIN     = 0;
    localparam int FLAG_LAST      = 1;
    localparam int FLAG_FROM      = 2;
    localparam int FLAG_INCORRECT = 3;
    localparam int FLAG_FAILED    = 4;
    localparam int FLAG_FAILURE   = 5;

    // Keywords right-justified: byte j counts back from the final character
    localparam logic [MAX_WORD_LEN*DATA_W-1:0] WORD_TEXT [WORD_COUNT] = '{
        "login:", "last", "from", "incorrect", "failed", "failure"
    };
    localparam int WORD_LEN [WORD_COUNT] = '{6, 4, 4, 9, 6, 7};

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_VERB     = 3'd1,
        PH_OPTION   = 3'd2,
        PH_SUB_BODY = 3'd3,
        PH_SUB_END  = 3'd4,
        PH_TEXT     = 3'd5
    } telcsk_phase_t;

    // Classified byte passed from the command skipper to the matcher
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              is_text;
        logic              last;
        logic              cmd_only;
    } telcsk_item_t;

    function automatic logic [DATA_W-1:0] fold_lower(input logic [DATA_W-1:0] c);
        if (c >= UPPER_A && c <= UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

/* rtl/telcsk_front.sv */
// Command skipper: tracks the telnet command phase and classifies each byte.
module telcsk_front
    import telcsk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [DATA_W-1:0]   data_byte,
    input  logic                last_byte,
    output telcsk_item_t        item
);

    telcsk_phase_t phase_reg;
    telcsk_phase_t phase_next;
    telcsk_phase_t phase_after;
    logic          take;

    assign take = in_valid && in_ready;

    // phase that this byte leaves behind
    always_comb
    begin
        unique case (phase_reg)
            PH_START:
            begin
                phase_after = (data_byte == IAC_CODE) ? PH_VERB : PH_TEXT;
            end
            PH_VERB:
            begin
                phase_after = (data_byte == SB_CODE) ? PH_SUB_BODY : PH_OPTION;
            end
            PH_OPTION:
            begin
                phase_after = PH_START;
            end
            PH_SUB_BODY:
            begin
                phase_after = (data_byte == IAC_CODE) ? PH_SUB_END : PH_SUB_BODY;
            end
            PH_SUB_END:
            begin
                phase_after = PH_START;
            end
            default:
            begin
                phase_after = PH_TEXT;
            end
        endcase
    end

    // next state: hold when idle, drop back to start at the end of a packet
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = last_byte ? PH_START : phase_after;
        end
    end

    // outputs: classify the byte for the matcher
    always_comb
    begin
        item.data     = data_byte;
        item.last     = last_byte;
        item.is_text  = (phase_after == PH_TEXT);
        item.cmd_only = (phase_after != PH_TEXT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

/* rtl/telcsk_queue.sv */
// Short request queue between the command skipper and the keyword matcher.
`include "telnet_command_strip_keyword_detect_macros.svh"
module telcsk_queue
    import telcsk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  telcsk_item_t push_item,
    output logic         pop_valid,
    input  logic         pop_ready,
    output telcsk_item_t pop_item
);

    telcsk_item_t      slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `TCSK_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= QCNT_W'(QUEUE_DEPTH), "queue occupancy beyond depth")
    `TCSK_ASSERT_NEXT(a_push_stall_full, clk, rst_n,
        push_valid && !push_ready && !pop_ready, !push_ready, "full queue freed without a pop")

endmodule

/* rtl/telcsk_back.sv */
// Keyword matcher: lower-cases text bytes, scans the history window and forms the result.
module telcsk_back
    import telcsk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  telcsk_item_t item,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         keyword_match,
    output logic         commands_only,
    output logic         prompt_hit,
    output logic         failure_word_hit
);

    logic [DATA_W-1:0]     window_reg  [WINDOW_BYTES];
    logic [DATA_W-1:0]     window_next [WINDOW_BYTES];
    logic [WORD_COUNT-1:0] flags_reg;
    logic [WORD_COUNT-1:0] flags_next;
    logic [WORD_COUNT-1:0] flags_upd;
    logic [WORD_COUNT-1:0] hits;
    logic                  ended_reg;
    logic                  ended_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  match_reg;
    logic                  cmd_only_reg;
    logic                  prompt_reg;
    logic                  failure_reg;
    logic                  prompt_now;
    logic                  failure_now;
    logic [DATA_W-1:0]     folded;
    logic                  take;
    logic                  scan;

    // a final byte waits until the result register is free
    assign item_ready = !item.last || !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;
    assign folded     = fold_lower(item.data);
    assign scan       = item.is_text && !ended_reg && (item.data != NUL_CODE);

    // compare every keyword against this byte and the window in parallel
    for (genvar w = 0; w < WORD_COUNT; w++)
    begin : g_word
        if (WORD_LEN[w] - 1 > WINDOW_BYTES)
        begin : g_too_long
            assign hits[w] = 1'b0;
        end
        else
        begin : g_cmp
            logic [MAX_WORD_LEN-1:0] pos_ok;
            assign pos_ok[0] = (folded == WORD_TEXT[w][DATA_W-1:0]);
            for (genvar k = 1; k < MAX_WORD_LEN; k++)
            begin : g_pos
                if (k < WORD_LEN[w])
                begin : g_used
                    assign pos_ok[k] = (window_reg[k-1] == WORD_TEXT[w][DATA_W*k +: DATA_W]);
                end
                else
                begin : g_unused
                    assign pos_ok[k] = 1'b1;
                end
            end
            assign hits[w] = &pos_ok;
        end
    end

    assign flags_upd   = scan ? (flags_reg | hits) : flags_reg;
    assign prompt_now  = flags_upd[FLAG_LOGIN] && !flags_upd[FLAG_LAST] && !flags_upd[FLAG_FROM];
    assign failure_now = flags_upd[FLAG_INCORRECT] || flags_upd[FLAG_FAILED]
                         || flags_upd[FLAG_FAILURE];

    always_comb
    begin
        window_next = window_reg;
        flags_next  = flags_reg;
        ended_next  = ended_reg;
        if (take)
        begin
            flags_next = flags_upd;
            if (item.is_text && !ended_reg && item.data == NUL_CODE)
            begin
                ended_next = 1'b1;
            end
            if (scan)
            begin
                window_next[0] = folded;
                for (int i = 1; i < WINDOW_BYTES; i++)
                begin
                    window_next[i] = window_reg[i-1];
                end
            end
            if (item.last)
            begin
                flags_next = '0;
                ended_next = 1'b0;
                for (int i = 0; i < WINDOW_BYTES; i++)
                begin
                    window_next[i] = '0;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (take && item.last)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_BYTES; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            flags_reg     <= flags_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
            window_reg    <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && item.last)
        begin
            match_reg    <= prompt_now || failure_now;
            cmd_only_reg <= item.cmd_only;
            prompt_reg   <= prompt_now;
            failure_reg  <= failure_now;
        end
    end

    assign out_valid        = out_valid_reg;
    assign keyword_match    = match_reg;
    assign commands_only    = cmd_only_reg;
    assign prompt_hit       = prompt_reg;
    assign failure_word_hit = failure_reg;

endmodule

/* rtl/telnet_command_strip_keyword_detect.sv */
// Top level of the telnet command strip and keyword detect block.
//
// Usage: feed a packet payload one byte per request on the input channel
// (in_valid / in_ready, fields data_byte and last_byte). Leading telnet
// commands (IAC verb option, and IAC SB ... IAC x subnegotiations) are
// skipped; the remaining text up to the first NUL is lower-cased and
// scanned for login:, last, from, incorrect, failed and failure.
// One result request leaves on the output channel (out_valid / out_ready)
// for each byte marked last_byte; other bytes give no result.
// Throughput: one byte per cycle, sustained while in_ready is high, set by
// the phase machine and the parallel window compares. A final byte is
// written into the queue, and the matcher registers the result as it
// takes the byte from the queue.
// Stalls: while out_ready is low a finished result holds in the output
// register; bytes keep flowing into the matcher until a further final byte
// arrives, then the two-entry queue fills and in_ready drops.
// Reset: rst_n clears the command phase, queue, window, flags and the
// output valid; the end of every packet also clears the phase, window and flags.
`include "telnet_command_strip_keyword_detect_macros.svh"
module telnet_command_strip_keyword_detect
    import telcsk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              keyword_match,
    output logic              commands_only,
    output logic              prompt_hit,
    output logic              failure_word_hit
);

    telcsk_item_t front_item;
    telcsk_item_t back_item;
    logic         back_valid;
    logic         back_ready;

    // classify each byte as command or text
    telcsk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .item      (front_item)
    );

    // decouple the skipper from the matcher so either side may stall
    telcsk_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    // scan text, hold flags and register the result
    telcsk_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (back_valid),
        .item_ready       (back_ready),
        .item             (back_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .keyword_match    (keyword_match),
        .commands_only    (commands_only),
        .prompt_hit       (prompt_hit),
        .failure_word_hit (failure_word_hit)
    );

    `TCSK_ASSERT_IMPLIES(a_cmd_only_no_prompt, clk, rst_n, out_valid && commands_only,
        !prompt_hit && !keyword_match, "prompt reported on a commands-only packet")
    `TCSK_ASSERT_IMPLIES(a_cmd_only_no_failure, clk, rst_n, out_valid && commands_only,
        !failure_word_hit, "failure word reported on a commands-only packet")

endmodule

/* tb/telnet_command_strip_keyword_detect_test.sv */
// Testbench for the telnet command strip and keyword detect block.
`timescale 1ns / 100ps

module telnet_command_strip_keyword_detect_test;
    import telcsk_pkg::*;

    // Cycles with no request accepted on either side before the run is abandoned.
    localparam int QUIET_LIMIT  = 4000;
    // Cycles to hold after the last result.
    localparam int TAIL_CYCLES  = 12;
    localparam int RANDOM_BYTES = 510;

    // Flags of one packet's verdict, in port order.
    typedef struct packed {
        logic keyword_match;
        logic commands_only;
        logic prompt_hit;
        logic failure_word_hit;
    } verdict_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [DATA_W-1:0] data_byte = '0;
    logic              last_byte = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              keyword_match;
    logic              commands_only;
    logic              prompt_hit;
    logic              failure_word_hit;

    telnet_command_strip_keyword_detect dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .keyword_match    (keyword_match),
        .commands_only    (commands_only),
        .prompt_hit       (prompt_hit),
        .failure_word_hit (failure_word_hit)
    );

    // 8 ns period: low half then high half.
    always begin
        #4 clk = 1'b0;
        #4 clk = 1'b1;
    end

    // Idle and stall percentages, changed between phases of the run.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int errors        = 0;
    int bytes_sent    = 0;
    int packets_sent  = 0;
    int verdicts_seen = 0;
    int match_count   = 0;
    int cmd_only_count = 0;

    // Predicted verdicts, oldest first, waiting for the block to deliver them.
    verdict_t pending_verdicts [$];
    verdict_t oldest_verdict;

    // Bytes of the packet being built, sent in order by send_packet.
    logic [7:0] pkt_bytes [$];

    // Shadow of the block's packet state, kept by the predictor.
    telcsk_phase_t skip_state;
    logic [7:0]    text_history [WINDOW_BYTES];
    logic [5:0]    words_seen;
    logic          text_closed;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic string keyword_text(input int idx);
        case (idx)
            FLAG_LOGIN:     return "login:";
            FLAG_LAST:      return "last";
            FLAG_FROM:      return "from";
            FLAG_INCORRECT: return "incorrect";
            FLAG_FAILED:    return "failed";
            default:        return "failure";
        endcase
    endfunction

    // Return the shadow state to what reset, or the end of a packet, leaves.
    task automatic clear_packet_state();
        skip_state  = PH_START;
        words_seen  = '0;
        text_closed = 1'b0;
        for (int k = 0; k < WINDOW_BYTES; k++)
        begin
            text_history[k] = '0;
        end
    endtask

    // Fold one text byte to lower case, match every keyword ending on it,
    // then shift it into the history. A NUL closes the text for good.
    task automatic scan_text_byte(input logic [7:0] raw);
        logic [7:0] folded;
        string      word;
        int         len;
        bit         same;
        if (text_closed)
            return;
        if (raw == NUL_CODE)
        begin
            text_closed = 1'b1;
            return;
        end
        folded = (raw >= UPPER_A && raw <= UPPER_Z) ? raw + CASE_OFFSET : raw;
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            word = keyword_text(w);
            len  = word.len();
            if (len - 1 > WINDOW_BYTES)
                continue;
            same = (folded == word[len-1]);
            for (int k = 0; k + 1 < len; k++)
            begin
                if (text_history[k] != word[len-2-k])
                    same = 1'b0;
            end
            if (same)
                words_seen[w] = 1'b1;
        end
        for (int k = WINDOW_BYTES - 1; k > 0; k--)
        begin
            text_history[k] = text_history[k-1];
        end
        text_history[0] = folded;
    endtask

    // Advance the command skipper on one accepted byte; on the final byte
    // queue the verdict and start afresh.
    task automatic predict_byte(input logic [7:0] b, input logic is_last);
        verdict_t v;
        case (skip_state)
            PH_START:
            begin
                if (b == IAC_CODE)
                    skip_state = PH_VERB;
                else
                begin
                    skip_state = PH_TEXT;
                    scan_text_byte(b);
                end
            end
            PH_VERB:     skip_state = (b == SB_CODE) ? PH_SUB_BODY : PH_OPTION;
            PH_OPTION:   skip_state = PH_START;
            PH_SUB_BODY:
            begin
                if (b == IAC_CODE)
                    skip_state = PH_SUB_END;
            end
            PH_SUB_END:  skip_state = PH_START;
            default:
            begin
                skip_state = PH_TEXT;
                scan_text_byte(b);
            end
        endcase
        if (is_last)
        begin
            v.commands_only    = (skip_state != PH_TEXT);
            v.prompt_hit       = words_seen[FLAG_LOGIN] && !words_seen[FLAG_LAST]
                                 && !words_seen[FLAG_FROM];
            v.failure_word_hit = words_seen[FLAG_INCORRECT] || words_seen[FLAG_FAILED]
                                 || words_seen[FLAG_FAILURE];
            v.keyword_match    = v.prompt_hit || v.failure_word_hit;
            if (v.keyword_match)
                match_count++;
            if (v.commands_only)
                cmd_only_count++;
            pending_verdicts.push_back(v);
            clear_packet_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one byte, idling first at the current rate, and hold it until the
    // request is taken. Inputs are sampled just after the edge, so in_ready
    // still shows the value that decided acceptance at that edge.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        predict_byte(b, is_last);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++)
        begin
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        end
        packets_sent++;
    endtask

    // Drop valid and hold off until every predicted verdict has arrived.
    task automatic wait_results_clear();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    // Append a string, or its first n characters, in random letter case.
    task automatic push_text(input string s, input int n);
        logic [7:0] ch;
        for (int i = 0; i < n; i++)
        begin
            ch = s[i];
            if (ch >= "a" && ch <= "z" && $urandom_range(0, 1))
                ch = ch - CASE_OFFSET;
            pkt_bytes.push_back(ch);
        end
    endtask

    // Append one complete command: a subnegotiation or a plain verb/option.
    task automatic push_command();
        logic [7:0] verb;
        pkt_bytes.push_back(IAC_CODE);
        if ($urandom_range(0, 2) == 0)
        begin
            pkt_bytes.push_back(SB_CODE);
            repeat ($urandom_range(0, 3))
                pkt_bytes.push_back(8'($urandom_range(0, 254)));
            pkt_bytes.push_back(IAC_CODE);
            pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            verb = 8'($urandom_range(0, 255));
            if (verb == SB_CODE)
                verb = 8'hfb;
            pkt_bytes.push_back(verb);
            pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Build one random packet. Most are leading commands followed by text made
    // of keywords, partial keywords and filler; some end inside a command, and
    // the rest are raw noise.
    task automatic build_random_packet();
        int    kind;
        int    sel;
        string word;
        pkt_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 12))
                pkt_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2))
            push_command();
        if (kind < 22)
        begin
            // Truncated tail: a lone IAC, IAC and verb, or an open subnegotiation.
            pkt_bytes.push_back(IAC_CODE);
            sel = $urandom_range(0, 2);
            if (sel == 1)
                pkt_bytes.push_back(8'($urandom_range(0, 255)));
            else if (sel == 2)
            begin
                pkt_bytes.push_back(SB_CODE);
                repeat ($urandom_range(0, 3))
                    pkt_bytes.push_back(8'($urandom_range(0, 254)));
                if ($urandom_range(0, 1))
                    pkt_bytes.push_back(IAC_CODE);
            end
            return;
        end
        if ($urandom_range(0, 14) == 0)
            pkt_bytes.push_back(NUL_CODE);
        repeat ($urandom_range(1, 3))
        begin
            sel = $urandom_range(0, 11);
            if (sel < 6)
            begin
                word = keyword_text(sel);
                push_text(word, word.len());
            end
            else if (sel < 8)
            begin
                word = keyword_text($urandom_range(0, WORD_COUNT - 1));
                push_text(word, $urandom_range(1, word.len() - 1));
            end
            else if (sel < 10)
            begin
                repeat ($urandom_range(1, 3))
                    pkt_bytes.push_back(8'($urandom_range(32, 126)));
            end
            else if (sel == 10)
                pkt_bytes.push_back(IAC_CODE);
            else
            begin
                // NUL mid-text: later words must be ignored.
                pkt_bytes.push_back(NUL_CODE);
                word = keyword_text($urandom_range(0, WORD_COUNT - 1));
                push_text(word, word.len());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic check_flag(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            errors++;
        end
    endtask

    // Compare each delivered verdict with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
            begin
                $error("verdict delivered with none predicted");
                errors++;
            end
            else
            begin
                oldest_verdict = pending_verdicts.pop_front();
                check_flag("keyword_match", oldest_verdict.keyword_match, keyword_match);
                check_flag("commands_only", oldest_verdict.commands_only, commands_only);
                check_flag("prompt_hit", oldest_verdict.prompt_hit, prompt_hit);
                check_flag("failure_word_hit", oldest_verdict.failure_word_hit,
                           failure_word_hit);
            end
        end
    end

    // Abandon the run once nothing has moved on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no request accepted for %0d cycles", QUIET_LIMIT);
        $display("telnet_command_strip_keyword_detect_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Capital letters, an IAC byte that lands in the text, then the prompt.
    task automatic test_prompt_with_text_iac();
        pkt_bytes.delete();
        pkt_bytes.push_back("Z");
        pkt_bytes.push_back(IAC_CODE);
        pkt_bytes.push_back("L");
        pkt_bytes.push_back("O");
        pkt_bytes.push_back("G");
        pkt_bytes.push_back("I");
        pkt_bytes.push_back("N");
        pkt_bytes.push_back(":");
        send_packet();
    endtask

    // Packet ends inside a subnegotiation body: commands only.
    task automatic test_truncated_subnegotiation();
        pkt_bytes.delete();
        pkt_bytes.push_back(IAC_CODE);
        pkt_bytes.push_back(SB_CODE);
        pkt_bytes.push_back(8'h01);
        send_packet();
    endtask

    // One complete plain command and nothing after it.
    task automatic test_complete_command_only();
        pkt_bytes.delete();
        pkt_bytes.push_back(IAC_CODE);
        pkt_bytes.push_back(8'h01);
        pkt_bytes.push_back(8'h02);
        send_packet();
    endtask

    // Text opening with NUL: not commands only, and later bytes are ignored.
    task automatic test_text_opening_nul();
        pkt_bytes.delete();
        pkt_bytes.push_back(NUL_CODE);
        pkt_bytes.push_back(IAC_CODE);
        pkt_bytes.push_back(UPPER_A);
        send_packet();
    endtask

    // Empty subnegotiation, then a failure word in mixed case.
    task automatic test_failure_after_subnegotiation();
        pkt_bytes.delete();
        pkt_bytes.push_back(IAC_CODE);
        pkt_bytes.push_back(SB_CODE);
        pkt_bytes.push_back(IAC_CODE);
        pkt_bytes.push_back(8'hf0);
        push_text("failed", 6);
        send_packet();
    endtask

    // Random packets until about the given number of bytes has gone in.
    task automatic test_random_traffic(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            build_random_packet();
            send_packet();
        end
    endtask

    initial
    begin
        clear_packet_state();
        // Hold reset, then release it on an edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases and the first random phase: sender mostly busy,
        // receiver stalling heavily.
        send_idle_pct  = 11;
        recv_stall_pct = 78;
        test_prompt_with_text_iac();
        test_truncated_subnegotiation();
        test_complete_command_only();
        test_text_opening_nul();
        test_failure_after_subnegotiation();
        test_random_traffic(RANDOM_BYTES);
        wait_results_clear();

        // Swap the pressure: sparse sender, eager receiver.
        send_idle_pct  = 78;
        recv_stall_pct = 11;
        test_random_traffic(RANDOM_BYTES);
        wait_results_clear();

        // Back to back, no idling on either side.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(RANDOM_BYTES);
        wait_results_clear();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d packets, checked %0d verdicts",
                 bytes_sent, packets_sent, verdicts_seen);
        $display("%0d packets matched a keyword rule, %0d held commands only",
                 match_count, cmd_only_count);
        if (errors == 0)
            $display("telnet_command_strip_keyword_detect_test: done, clean");
        else
            $display("telnet_command_strip_keyword_detect_test: done, errors");
        $finish;
    end

endmodule
